### hdl/ute_pkg.sv
// ----------------------------------------------------------------------------
// ute_pkg
// Shared types, constants and the step sequence of the tracking estimator.
// ----------------------------------------------------------------------------
package ute_pkg;

  localparam int unsigned UOP_LAST = 25;

  localparam logic signed [33:0] COEF0 = 34'sd1686629713;
  localparam logic signed [33:0] COEF1 = 34'sd693598669;
  localparam logic signed [33:0] COEF2 = 34'sd85569306;
  localparam logic signed [33:0] COEF3 = 34'sd5026995;
  localparam logic signed [33:0] COEF4 = 34'sd172272;
  localparam logic signed [33:0] INV_TWO_PI = 34'sd683565276;
  localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;

  localparam logic [2:0] REG_GAIN_KP      = 3'd0;
  localparam logic [2:0] REG_INV_OFFSET_P = 3'd1;
  localparam logic [2:0] REG_STEP_TIME    = 3'd2;
  localparam logic [2:0] REG_INIT_X       = 3'd3;
  localparam logic [2:0] REG_INIT_Y       = 3'd4;
  localparam logic [2:0] REG_INIT_HEADING = 3'd5;

  typedef enum logic [4:0] {
    U_SQ, U_P3, U_P2, U_P1, U_P0, U_SR,
    U_VX, U_VY, U_V1, U_V2, U_T1, U_T2, U_W,
    U_XD, U_YD, U_PX, U_PY, U_D, U_G1, U_G2
  } uop_t;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  typedef struct packed {
    logic load;
    logic wb;
    logic out_load;
    logic sel_cos;
    uop_t uop;
  } dp_cmd_t;

  // cosine first, then sine, then the command and pose chain
  function automatic uop_t seq_uop(input logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0, 5'd6:   u = U_SQ;
      5'd1, 5'd7:   u = U_P3;
      5'd2, 5'd8:   u = U_P2;
      5'd3, 5'd9:   u = U_P1;
      5'd4, 5'd10:  u = U_P0;
      5'd5, 5'd11:  u = U_SR;
      5'd12:        u = U_VX;
      5'd13:        u = U_VY;
      5'd14:        u = U_V1;
      5'd15:        u = U_V2;
      5'd16:        u = U_T1;
      5'd17:        u = U_T2;
      5'd18:        u = U_W;
      5'd19:        u = U_XD;
      5'd20:        u = U_YD;
      5'd21:        u = U_PX;
      5'd22:        u = U_PY;
      5'd23:        u = U_D;
      5'd24:        u = U_G1;
      default:      u = U_G2;
    endcase
    return u;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -68'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### hdl/ute_if.sv
// ----------------------------------------------------------------------------
// ute_in_if / ute_out_if
// Valid/ready channels for reference items and pose results.
// ----------------------------------------------------------------------------
interface ute_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic [7:0]         step_count;
  logic               restart;
  modport source (output valid, ref_x, ref_y, step_count, restart, input ready);
  modport sink   (input valid, ref_x, ref_y, step_count, restart, output ready);
endinterface

interface ute_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic [31:0]        est_heading;
  logic signed [31:0] cmd_vx;
  logic signed [31:0] cmd_vy;
  modport source (output valid, est_x, est_y, est_heading, cmd_vx, cmd_vy, input ready);
  modport sink   (input valid, est_x, est_y, est_heading, cmd_vx, cmd_vy, output ready);
endinterface

### hdl/ute_ctrl.sv
// ----------------------------------------------------------------------------
// ute_ctrl
// Sequencer: walks the micro-op list once per step, counts steps, hands off.
// ----------------------------------------------------------------------------
module ute_ctrl #(
  parameter int unsigned MAX_STEPS = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_step_count,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ute_pkg::dp_cmd_t cmd
);

  ute_pkg::state_t state_r, state_nxt;
  logic [4:0] uidx_r, uidx_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] n_eff;

  always_comb begin
    if (32'(in_step_count) > MAX_STEPS) n_eff = 8'(MAX_STEPS);
    else n_eff = in_step_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ute_pkg::S_IDLE;
      uidx_r      <= '0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uidx_r      <= uidx_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    uidx_nxt      = uidx_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.wb        = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.sel_cos   = (uidx_r < 5'd6);
    cmd.uop       = ute_pkg::seq_uop(uidx_r);
    unique case (state_r)
      ute_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          uidx_nxt  = '0;
          phase_nxt = 1'b0;
          cnt_nxt   = n_eff;
          state_nxt = (n_eff == 8'd0) ? ute_pkg::S_DONE : ute_pkg::S_RUN;
        end
      end
      ute_pkg::S_RUN: begin
        cmd.wb    = phase_r;
        phase_nxt = ~phase_r;
        if (phase_r) begin
          if (uidx_r == 5'(ute_pkg::UOP_LAST)) begin
            uidx_nxt = '0;
            cnt_nxt  = cnt_r - 8'd1;
            if (cnt_r == 8'd1) state_nxt = ute_pkg::S_DONE;
          end else begin
            uidx_nxt = uidx_r + 5'd1;
          end
        end
      end
      ute_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ute_pkg::S_IDLE;
        end
      end
      default: state_nxt = ute_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/ute_datapath.sv
// ----------------------------------------------------------------------------
// ute_datapath
// Registers, config and one shared 34x34 multiplier with write-back logic.
// ----------------------------------------------------------------------------
module ute_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ute_pkg::dp_cmd_t   cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic               in_restart,
  output logic signed [31:0] est_x,
  output logic signed [31:0] est_y,
  output logic [31:0]        est_heading,
  output logic signed [31:0] cmd_vx,
  output logic signed [31:0] cmd_vy
);

  logic [23:0] kp_r, invp_r;
  logic [31:0] ts_r, ix_r, iy_r, ih_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [31:0] px_r, py_r;
  logic [31:0]        hd_r;
  logic signed [31:0] vx_r, vy_r, v_r, t_r, w_r;
  logic signed [31:0] c_r, s_r, sarg_r, z_r, p_r;
  logic signed [32:0] xd_r, yd_r;
  logic [63:0]        d_r;
  logic signed [67:0] acc_r, prod_r;
  logic signed [31:0] ox_r, oy_r, ovx_r, ovy_r;
  logic [31:0]        oh_r;

  logic [31:0]        ang;
  logic signed [31:0] fold;
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] sh30, sh16, sh32;

  // fold the angle into the half turn around zero
  always_comb begin
    ang = cmd.sel_cos ? hd_r + ute_pkg::QUARTER_TURN : hd_r;
    if ($signed(ang) > 32'sh4000_0000 || $signed(ang) < -32'sh4000_0000)
      fold = $signed(32'h8000_0000 - ang);
    else
      fold = $signed(ang);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.uop)
      ute_pkg::U_SQ: begin op_a = 34'(fold); op_b = 34'(fold); end
      ute_pkg::U_P3: begin op_a = 34'(z_r); op_b = ute_pkg::COEF4; end
      ute_pkg::U_P2, ute_pkg::U_P1, ute_pkg::U_P0: begin
        op_a = 34'(z_r); op_b = 34'(p_r);
      end
      ute_pkg::U_SR: begin op_a = 34'(sarg_r); op_b = 34'(p_r); end
      ute_pkg::U_VX: begin
        op_a = $signed({10'd0, kp_r});
        op_b = 34'(rx_r) - 34'(px_r);
      end
      ute_pkg::U_VY: begin
        op_a = $signed({10'd0, kp_r});
        op_b = 34'(ry_r) - 34'(py_r);
      end
      ute_pkg::U_V1: begin op_a = 34'(vx_r); op_b = 34'(c_r); end
      ute_pkg::U_V2: begin op_a = 34'(vy_r); op_b = 34'(s_r); end
      ute_pkg::U_T1: begin op_a = 34'(vy_r); op_b = 34'(c_r); end
      ute_pkg::U_T2: begin op_a = 34'(vx_r); op_b = 34'(s_r); end
      ute_pkg::U_W:  begin op_a = 34'(t_r); op_b = $signed({10'd0, invp_r}); end
      ute_pkg::U_XD: begin op_a = 34'(v_r); op_b = 34'(c_r); end
      ute_pkg::U_YD: begin op_a = 34'(v_r); op_b = 34'(s_r); end
      ute_pkg::U_PX: begin op_a = 34'(xd_r); op_b = $signed({2'd0, ts_r}); end
      ute_pkg::U_PY: begin op_a = 34'(yd_r); op_b = $signed({2'd0, ts_r}); end
      ute_pkg::U_D:  begin op_a = 34'(w_r); op_b = $signed({2'd0, ts_r}); end
      ute_pkg::U_G1: begin
        op_a = $signed({2'd0, d_r[63:32]}); op_b = ute_pkg::INV_TWO_PI;
      end
      ute_pkg::U_G2: begin
        op_a = $signed({2'd0, d_r[31:0]}); op_b = ute_pkg::INV_TWO_PI;
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign sh30 = prod_r >>> 30;
  assign sh16 = prod_r >>> 16;
  assign sh32 = prod_r >>> 32;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= 24'd65536;
      invp_r <= 24'd655360;
      ts_r   <= 32'd42949673;
      ix_r   <= '0;
      iy_r   <= '0;
      ih_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ute_pkg::REG_GAIN_KP:      kp_r   <= cfg_data[23:0];
        ute_pkg::REG_INV_OFFSET_P: invp_r <= cfg_data[23:0];
        ute_pkg::REG_STEP_TIME:    ts_r   <= cfg_data;
        ute_pkg::REG_INIT_X:       ix_r   <= cfg_data;
        ute_pkg::REG_INIT_Y:       iy_r   <= cfg_data;
        ute_pkg::REG_INIT_HEADING: ih_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
    end else if (cmd.load) begin
      rx_r <= in_ref_x;
      ry_r <= in_ref_y;
      if (in_restart) begin
        px_r <= $signed(ix_r);
        py_r <= $signed(iy_r);
        hd_r <= ih_r;
      end
    end else if (cmd.wb) begin
      unique case (cmd.uop)
        ute_pkg::U_SQ: begin sarg_r <= fold; z_r <= sh30[31:0]; end
        ute_pkg::U_P3: p_r <= 32'(ute_pkg::COEF3 - sh30[33:0]);
        ute_pkg::U_P2: p_r <= 32'(ute_pkg::COEF2 - sh30[33:0]);
        ute_pkg::U_P1: p_r <= 32'(ute_pkg::COEF1 - sh30[33:0]);
        ute_pkg::U_P0: p_r <= 32'(ute_pkg::COEF0 - sh30[33:0]);
        ute_pkg::U_SR: begin
          // clamp to plus or minus one in Q2.30
          if (sh30 > 68'sd1073741824) begin
            if (cmd.sel_cos) c_r <= 32'sd1073741824; else s_r <= 32'sd1073741824;
          end else if (sh30 < -68'sd1073741824) begin
            if (cmd.sel_cos) c_r <= -32'sd1073741824; else s_r <= -32'sd1073741824;
          end else begin
            if (cmd.sel_cos) c_r <= sh30[31:0]; else s_r <= sh30[31:0];
          end
        end
        ute_pkg::U_VX: vx_r <= ute_pkg::sat32(sh16);
        ute_pkg::U_VY: vy_r <= ute_pkg::sat32(sh16);
        ute_pkg::U_V1, ute_pkg::U_T1, ute_pkg::U_G1: acc_r <= prod_r;
        ute_pkg::U_V2: v_r <= ute_pkg::sat32((acc_r + prod_r) >>> 30);
        ute_pkg::U_T2: t_r <= ute_pkg::sat32((acc_r - prod_r) >>> 30);
        ute_pkg::U_W:  w_r <= ute_pkg::sat32(sh16);
        ute_pkg::U_XD: xd_r <= sh30[32:0];
        ute_pkg::U_YD: yd_r <= sh30[32:0];
        ute_pkg::U_PX: px_r <= ute_pkg::sat32(68'(px_r) + sh32);
        ute_pkg::U_PY: py_r <= ute_pkg::sat32(68'(py_r) + sh32);
        ute_pkg::U_D:  d_r <= sh16[63:0];
        ute_pkg::U_G2: hd_r <= hd_r + acc_r[31:0] + prod_r[63:32];
        default: ;
      endcase
    end
  end

  // result register, so the next item may start while this one waits
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ox_r  <= px_r;
      oy_r  <= py_r;
      oh_r  <= hd_r;
      ovx_r <= vx_r;
      ovy_r <= vy_r;
    end
  end

  assign est_x       = ox_r;
  assign est_y       = oy_r;
  assign est_heading = oh_r;
  assign cmd_vx      = ovx_r;
  assign cmd_vy      = ovy_r;

endmodule

### hdl/unicycle_tracking_estimator.sv
// ----------------------------------------------------------------------------
// unicycle_tracking_estimator
// Point tracking of a unicycle: P command, heading rotation, Euler step.
// Each step runs 26 products through the one shared multiplier.
// An item is taken only once the last has run all its steps, and it may be
// taken while that result still waits in the output register.
// Synchronous reset restores the config register defaults and zeroes the pose.
// ----------------------------------------------------------------------------
module unicycle_tracking_estimator #(
  parameter int unsigned MAX_STEPS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  ute_in_if.sink      in_bus,
  ute_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ute_pkg::dp_cmd_t cmd;

  ute_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_bus.valid),
    .in_step_count (in_bus.step_count),
    .in_ready      (in_bus.ready),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .cmd           (cmd)
  );

  ute_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ref_x    (in_bus.ref_x),
    .in_ref_y    (in_bus.ref_y),
    .in_restart  (in_bus.restart),
    .est_x       (out_bus.est_x),
    .est_y       (out_bus.est_y),
    .est_heading (out_bus.est_heading),
    .cmd_vx      (out_bus.cmd_vx),
    .cmd_vy      (out_bus.cmd_vy)
  );

endmodule
